>>> hw/rtl/glmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package glmc_pkg;

    localparam int DEF_MAX_COLS     = 1024;
    localparam int DEF_MAX_ROWS     = 1024;
    localparam int DEF_SAMPLE_WIDTH = 16;

    // Configuration register file.
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'd1;

    // Result count.
    localparam int COUNT_W = 20;
    localparam int OUT_TDATA_W = ((COUNT_W + 7) / 8) * 8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

endpackage

`default_nettype wire

>>> hw/rtl/glmc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module glmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/grid_local_minimum_counter.sv
`timescale 1ns / 1ps
`default_nettype none

// Counts the strict four-neighbor local minima of a raster frame of signed samples. The frame
// size comes from num_rows and num_cols (2 to MAX_ROWS and 2 to MAX_COLS, values outside are
// clamped); a register write restarts the frame. One sample is taken every clock cycle: each
// sample needs one read of each of the two line-store RAMs, issued in the cycle it is taken,
// and the compares run in the following cycle. The count of a frame is presented on the result
// channel from the clock edge that follows the one at which its last sample is taken, and is
// cleared for the next frame. Input stalls only when the last sample of a frame arrives while
// the previous count is still waiting. Line-store words read before they are written never reach a
// compare, so no clearing pass follows reset.

module grid_local_minimum_counter
    import glmc_pkg::*;
#(
    parameter int MAX_COLS     = DEF_MAX_COLS,
    parameter int MAX_ROWS     = DEF_MAX_ROWS,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    localparam int IN_TDATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // sample

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata    // minimum_count
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);

    function automatic logic [31:0] clamp_last(input logic [CFG_W-1:0] v, input int maxv);
        logic [31:0] n;
        n = 32'(v);
        if (n < 32'd2)
        begin
            n = 32'd2;
        end
        else if (n > 32'(maxv))
        begin
            n = 32'(maxv);
        end
        return n - 32'd1;
    endfunction

    logic                 in_accept;
    logic                 cfg_restart;
    logic [ROW_W-1:0]     rows_last_reg;
    logic [COL_W-1:0]     cols_last_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [COL_W-1:0]     col_reg;
    logic                 in_row_end;
    logic                 in_last_row;
    logic                 in_frame_end;

    logic                    s1_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_sample_reg;
    logic [COL_W-1:0]        s1_col_reg;
    logic                    s1_row_ge1_reg;
    logic                    s1_row_ge2_reg;
    logic                    s1_col_ge1_reg;
    logic                    s1_col_ge2_reg;
    logic                    s1_row_end_reg;
    logic                    s1_last_row_reg;

    logic signed [SAMPLE_WIDTH-1:0] prior_rd;
    logic signed [SAMPLE_WIDTH-1:0] older_rd;
    logic signed [SAMPLE_WIDTH-1:0] pv;
    logic signed [SAMPLE_WIDTH-1:0] pv_left_reg;
    logic signed [SAMPLE_WIDTH-1:0] pv_left2_reg;
    logic signed [SAMPLE_WIDTH-1:0] older_left_reg;
    logic signed [SAMPLE_WIDTH-1:0] cur_left_reg;
    logic signed [SAMPLE_WIDTH-1:0] cur_left2_reg;

    logic                 hit_above_left;
    logic                 hit_above;
    logic                 hit_left;
    logic                 hit_here;
    logic [2:0]           inc;
    logic [COUNT_W:0]     count_sum;
    logic [COUNT_W-1:0]   count_sat;
    logic                 s1_frame_end;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 out_valid_reg;
    logic [COUNT_W-1:0]   out_count_reg;

    assign cfg_restart  = cfg_we;
    assign in_row_end   = (col_reg == cols_last_reg);
    assign in_last_row  = (row_reg == rows_last_reg);
    assign in_frame_end = in_row_end && in_last_row;

    // The last sample of a frame needs a free result register when its count is written.
    assign s_axis_tready = !(in_frame_end && out_valid_reg && !m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_last_reg <= ROW_W'(clamp_last(CFG_W'(2), MAX_ROWS));
            cols_last_reg <= COL_W'(clamp_last(CFG_W'(2), MAX_COLS));
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_ROWS: rows_last_reg <= ROW_W'(clamp_last(cfg_data, MAX_ROWS));
                CFG_NUM_COLS: cols_last_reg <= COL_W'(clamp_last(cfg_data, MAX_COLS));
                default:      rows_last_reg <= rows_last_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cfg_restart)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (in_accept)
        begin
            if (in_row_end)
            begin
                col_reg <= '0;
                row_reg <= in_last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_sample_reg   <= s_axis_tdata[SAMPLE_WIDTH-1:0];
            s1_col_reg      <= col_reg;
            s1_row_ge1_reg  <= (row_reg != '0);
            s1_row_ge2_reg  <= (row_reg > ROW_W'(1));
            s1_col_ge1_reg  <= (col_reg != '0);
            s1_col_ge2_reg  <= (col_reg > COL_W'(1));
            s1_row_end_reg  <= in_row_end;
            s1_last_row_reg <= in_last_row;
        end
    end

    glmc_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_COLS)
    ) u_prior_row (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_sample_reg),
        .re    (in_accept),
        .raddr (col_reg),
        .rdata (prior_rd)
    );

    glmc_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_COLS)
    ) u_older_row (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (pv),
        .re    (in_accept),
        .raddr (col_reg),
        .rdata (older_rd)
    );

    assign pv = s1_row_ge1_reg ? prior_rd : '0;

    // The cell above and to the left is decided here, once its right neighbor has been read.
    always_comb
    begin
        hit_above_left = s1_row_ge1_reg && s1_col_ge1_reg
                         && (pv_left_reg < cur_left_reg)
                         && (pv_left_reg < pv)
                         && (!s1_row_ge2_reg || (pv_left_reg < older_left_reg))
                         && (!s1_col_ge2_reg || (pv_left_reg < pv_left2_reg));
        hit_above      = s1_row_ge1_reg && s1_row_end_reg
                         && (pv < s1_sample_reg)
                         && (pv < pv_left_reg)
                         && (!s1_row_ge2_reg || (pv < older_rd));
        hit_left       = s1_row_ge1_reg && s1_last_row_reg && s1_col_ge1_reg
                         && (cur_left_reg < s1_sample_reg)
                         && (cur_left_reg < pv_left_reg)
                         && (!s1_col_ge2_reg || (cur_left_reg < cur_left2_reg));
        hit_here       = s1_row_ge1_reg && s1_last_row_reg && s1_row_end_reg
                         && (s1_sample_reg < pv)
                         && (s1_sample_reg < cur_left_reg);
        inc = 3'(hit_above_left) + 3'(hit_above) + 3'(hit_left) + 3'(hit_here);
    end

    assign count_sum    = {1'b0, count_reg} + (COUNT_W + 1)'(inc);
    assign count_sat    = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];
    assign s1_frame_end = s1_row_end_reg && s1_last_row_reg;

    always_comb
    begin
        count_next = count_reg;
        if (cfg_restart)
        begin
            count_next = '0;
        end
        else if (s1_valid_reg)
        begin
            count_next = s1_frame_end ? '0 : count_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            pv_left_reg    <= pv;
            pv_left2_reg   <= pv_left_reg;
            older_left_reg <= older_rd;
            cur_left_reg   <= s1_sample_reg;
            cur_left2_reg  <= cur_left_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_valid_reg && s1_frame_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_frame_end)
        begin
            out_count_reg <= count_sat;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_count_reg);

`ifndef SYNTHESIS
    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_frame_end |-> !out_valid_reg)
        else $error("Frame result would overwrite a pending transaction.");

    a_result_follows_frame: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_frame_end |=> m_axis_tvalid)
        else $error("Frame end did not produce a result transaction.");

    a_column_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= cols_last_reg && row_reg <= rows_last_reg)
        else $error("Raster position is outside the configured frame.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_frame_end && out_valid_reg && !m_axis_tready)
        else $error("Input stalled without a blocked result.");
`endif

endmodule

`default_nettype wire

>>> tb/tb_grid_local_minimum_counter.sv
`timescale 1ns / 1ps

module tb_grid_local_minimum_counter;

    import glmc_pkg::*;

    localparam int SAMPLE_W       = DEF_SAMPLE_WIDTH;
    localparam int GRID_COLS      = DEF_MAX_COLS;
    localparam int GRID_ROWS      = DEF_MAX_ROWS;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 300;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [COUNT_W-1:0] count_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [SAMPLE_W-1:0]    s_axis_tdata;   // sample
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // minimum_count

    grid_local_minimum_counter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow of the block's frame state.
    logic [CFG_W-1:0] rows_setting;
    logic [CFG_W-1:0] cols_setting;
    sample_t          older_row [GRID_COLS];
    sample_t          prior_row [GRID_COLS];
    sample_t          left_window [3];
    int unsigned      row_pos;
    int unsigned      col_pos;
    count_t           minima_so_far;
    count_t           pending_counts [$];

    int  error_count;
    int  idle_cycles;
    bit  steady;
    bit  hold_request;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v, input int unsigned maxv);
        if (v < 2)
        begin
            return 2;
        end
        if (v > maxv)
        begin
            return maxv;
        end
        return 32'(v);
    endfunction

    function automatic int unsigned frame_cells();
        return clamp_size(rows_setting, GRID_ROWS) * clamp_size(cols_setting, GRID_COLS);
    endfunction

    function automatic sample_t pick_sample(input int unsigned mode);
        int unsigned v;
        if (mode == 0)
        begin
            v = $urandom_range(0, 4) - 2;
            return sample_t'(v);
        end
        if (mode == 1)
        begin
            return sample_t'($urandom);
        end
        case ($urandom_range(0, 5))
            0: return sample_t'(16'h8000);
            1: return sample_t'(16'h8001);
            2: return sample_t'(16'hFFFF);
            3: return sample_t'(16'h0000);
            4: return sample_t'(16'h7FFE);
            default: return sample_t'(16'h7FFF);
        endcase
    endfunction

    function automatic void bump_minima();
        if (minima_so_far < COUNT_MAX)
        begin
            minima_so_far++;
        end
    endfunction

    function automatic void restart_frame();
        row_pos       = 0;
        col_pos       = 0;
        minima_so_far = '0;
    endfunction

    // Decides the cells that this sample completes and advances the raster position.
    function automatic void track_minima(input sample_t s);
        int unsigned n;
        int unsigned m;
        int unsigned r;
        int unsigned c;
        logic        row_end;
        logic        last_row;
        logic        ok;
        sample_t     pv;
        sample_t     pv_left;
        sample_t     v;
        n        = clamp_size(rows_setting, GRID_ROWS);
        m        = clamp_size(cols_setting, GRID_COLS);
        r        = row_pos;
        c        = col_pos;
        row_end  = (c + 1 >= m);
        last_row = (r + 1 >= n);
        pv       = '0;
        pv_left  = left_window[0];
        if (r >= 1)
        begin
            pv = prior_row[c];
            ok = (pv < s);
            if (r >= 2 && !(pv < older_row[c]))
            begin
                ok = 1'b0;
            end
            if (c >= 1 && !(pv < pv_left))
            begin
                ok = 1'b0;
            end
            if (c + 1 < m && !(pv < prior_row[c + 1]))
            begin
                ok = 1'b0;
            end
            if (ok)
            begin
                bump_minima();
            end
        end
        if (last_row && r >= 1)
        begin
            if (c >= 1)
            begin
                v  = left_window[1];
                ok = (v < s) && (v < pv_left);
                if (c >= 2 && !(v < left_window[2]))
                begin
                    ok = 1'b0;
                end
                if (ok)
                begin
                    bump_minima();
                end
            end
            if (row_end)
            begin
                ok = (s < pv);
                if (c >= 1 && !(s < left_window[1]))
                begin
                    ok = 1'b0;
                end
                if (ok)
                begin
                    bump_minima();
                end
            end
        end
        left_window[0] = pv;
        older_row[c]   = pv;
        prior_row[c]   = s;
        left_window[2] = left_window[1];
        left_window[1] = s;
        if (!row_end)
        begin
            col_pos = c + 1;
        end
        else if (!last_row)
        begin
            col_pos = 0;
            row_pos = r + 1;
        end
        else
        begin
            pending_counts.push_back(minima_so_far);
            restart_frame();
        end
    endfunction

    task automatic send_sample(input sample_t value);
        while (!steady && $urandom_range(0, 99) < 19)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        track_minima(value);
        @(negedge clk);
    endtask

    task automatic send_samples(input int unsigned count, input int unsigned mode);
        repeat (count)
        begin
            send_sample(pick_sample(mode));
        end
    endtask

    // Stops the sender and waits until every count has arrived and the pipeline is empty.
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_counts.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (index == CFG_NUM_ROWS)
        begin
            rows_setting = value;
        end
        else
        begin
            cols_setting = value;
        end
        restart_frame();
        @(negedge clk);
    endtask

    task automatic set_grid(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        quiesce();
        write_register(CFG_NUM_ROWS, rows);
        write_register(CFG_NUM_COLS, cols);
    endtask

    task automatic test_directed_patterns();
        sample_t extremes [4]  = '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000};
        sample_t center [9]    = '{5, 4, 5, 4, 1, 4, 5, 4, 0};
        sample_t bottom [6]    = '{9, 9, 9, 3, 5, 7};
        // The reset size is two by two, so the first frames need no register write.
        foreach (extremes[i])
        begin
            send_sample(extremes[i]);
        end
        repeat (4)
        begin
            send_sample(sample_t'(-7));
        end
        set_grid(3, 3);
        foreach (center[i])
        begin
            send_sample(center[i]);
        end
        set_grid(2, 3);
        foreach (bottom[i])
        begin
            send_sample(bottom[i]);
        end
    endtask

    task automatic test_clamped_sizes();
        set_grid(0, 1);
        send_samples(4, 0);
        set_grid(1, 0);
        send_samples(4, 2);
    endtask

    task automatic test_abandoned_frame();
        set_grid(4, 4);
        send_samples(7, 0);
        quiesce();
        write_register(CFG_NUM_COLS, 5);
        send_samples(frame_cells(), 0);
        send_samples(9, 1);
        quiesce();
        write_register(CFG_NUM_ROWS, 4);
        send_samples(frame_cells(), 0);
    endtask

    task automatic test_backpressure();
        set_grid(2, 2);
        steady       = 1'b1;
        hold_request = 1'b1;
        repeat (12)
        begin
            send_samples(4, 0);
        end
        steady = 1'b0;
        quiesce();
    endtask

    task automatic test_tallest_grid();
        set_grid(100, 0);
        send_samples(frame_cells(), 0);
    endtask

    task automatic test_widest_grid();
        set_grid(1, 256);
        send_samples(frame_cells(), 0);
    endtask

    function automatic logic [CFG_W-1:0] pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
        begin
            return CFG_W'($urandom_range(0, 1));
        end
        if (roll < 10)
        begin
            return CFG_W'($urandom_range(9, 32));
        end
        return CFG_W'($urandom_range(2, 8));
    endfunction

    function automatic int unsigned pick_mode();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
        begin
            return 0;
        end
        if (roll < 8)
        begin
            return 1;
        end
        return 2;
    endfunction

    task automatic test_random_frames();
        int unsigned sent;
        int unsigned mode;
        int unsigned partial;
        int unsigned roll;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
            begin
                set_grid(pick_size(), pick_size());
            end
            else if (roll < 65)
            begin
                quiesce();
                write_register(CFG_NUM_ROWS, pick_size());
            end
            else if (roll < 80)
            begin
                quiesce();
                write_register(CFG_NUM_COLS, pick_size());
            end
            steady = (sent >= 60 && sent < 200);
            mode   = pick_mode();
            if ($urandom_range(0, 99) < 8)
            begin
                // A frame cut short by a register write.
                partial = $urandom_range(1, frame_cells() - 1);
                send_samples(partial, mode);
                quiesce();
                write_register(CFG_NUM_COLS, cols_setting);
                sent += partial;
            end
            else
            begin
                send_samples(frame_cells(), mode);
                sent += frame_cells();
            end
            if ($urandom_range(0, 99) < 5)
            begin
                quiesce();
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        int unsigned hold_left;
        m_axis_tready = 1'b0;
        hold_left     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_axis_tready <= steady || ($urandom_range(0, 99) >= 19);
            end
        end
    end

    always @(posedge clk)
    begin
        count_t expected;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_counts.size() == 0)
            begin
                $error("minimum_count unexpected: expected none, actual %0d", m_axis_tdata);
                error_count++;
            end
            else
            begin
                expected = pending_counts.pop_front();
                if (m_axis_tdata !== OUT_TDATA_W'(expected))
                begin
                    $error("minimum_count mismatch: expected %0d, actual %0d",
                           expected, m_axis_tdata);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        error_count   = 0;
        idle_cycles   = 0;
        steady        = 1'b0;
        hold_request  = 1'b0;
        rows_setting  = 2;
        cols_setting  = 2;
        left_window   = '{default: '0};
        restart_frame();
        repeat (11)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_patterns();
        test_clamped_sizes();
        test_abandoned_frame();
        test_backpressure();
        test_tallest_grid();
        test_widest_grid();
        test_random_frames();

        quiesce();
        repeat (SETTLE_CYCLES)
        begin
            @(posedge clk);
        end
        if (error_count == 0 && pending_counts.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/glmc_pkg.sv
hw/rtl/glmc_ram.sv
hw/rtl/grid_local_minimum_counter.sv
tb/tb_grid_local_minimum_counter.sv
